[hdl/iog_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iog_pkg
// shared sizes and helpers for the interval overlap grouper
// ----------------------------------------------------------------------------
package iog_pkg;

   localparam int MAX_GROUPS = 256;
   localparam int POS_W      = 32;
   localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
   localparam int OUT_IDX_W  = 8;
   localparam int ENTRY_W    = 2 * POS_W;

   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [OUT_IDX_W-1:0] out_idx_type;

   typedef struct packed {
      pos_type low;
      pos_type high;
   } entry_type;

   // first-fit hit test between stored [lo, hi] and new [s, e]
   function automatic logic overlaps(pos_type lo, pos_type hi, pos_type s, pos_type e);
      logic s_in;
      logic e_in;
      logic spans;
      s_in  = (s >= lo) && (s <= hi);
      e_in  = (e >= lo) && (e <= hi);
      spans = (s < lo) && (e > hi);
      return s_in || e_in || spans;
   endfunction

   // low eight bits of a block index
   function automatic out_idx_type to_out_idx(idx_type i);
      logic [IDX_W+OUT_IDX_W-1:0] ext;
      ext = {{OUT_IDX_W{1'b0}}, i};
      return ext[OUT_IDX_W-1:0];
   endfunction

endpackage

[hdl/iog_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iog_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module iog_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/interval_overlap_grouper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_overlap_grouper
// first-fit grouping of read intervals into a table of block intervals
// ----------------------------------------------------------------------------
// usage
//   a read [req_start_pos, req_end_pos] is transferred in when start is high
//   and busy is low. the block scans its block table from index 0, one entry
//   per cycle out of a single ram with a registered read, and stops at the
//   first block that overlaps the read. that block is widened to the union
//   and its index is returned; with no hit a new block is appended, or with a
//   full table rsp_overflow is raised and nothing is stored.
//   each transfer gives exactly one result, shown for one cycle with
//   rsp_valid high; the receiver cannot hold it off.
//   timing: busy is high while the scan examines blocks, one per cycle from
//   index 0; the registered result appears once the scan stops at a hit or
//   at the last stored block. with an empty table the result follows in the
//   next cycle and busy stays low. the scan length is set by the single ram
//   read port walking the table.
//   reset clears the state, scan index, block count and rsp_valid; the table
//   contents are never used before they are written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_overlap_grouper (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  iog_pkg::pos_type      req_start_pos,
   input  iog_pkg::pos_type      req_end_pos,
   output logic                  rsp_valid,
   output iog_pkg::out_idx_type  rsp_group_index,
   output logic                  rsp_opened_new,
   output logic                  rsp_overflow
);
   import iog_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // control and result registers
   state_type   state_ff,     state_in;
   idx_type     chk_idx_ff,   chk_idx_in;
   cnt_type     count_ff,     count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   out_idx_type rsp_idx_ff,   rsp_idx_in;
   logic        rsp_new_ff,   rsp_new_in;
   logic        rsp_ovf_ff,   rsp_ovf_in;

   // latched read interval (payload, no reset)
   pos_type     s_ff, s_in;
   pos_type     e_ff, e_in;

   // ram side
   logic        wr_en;
   idx_type     wr_addr;
   entry_type   wr_entry;
   idx_type     rd_addr;
   entry_type   rd_entry;
   logic [ENTRY_W-1:0] rd_raw;

   logic        accept;
   logic        hit;
   logic        last_entry;
   logic        table_full;

   iog_ram #(
      .DEPTH (MAX_GROUPS),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry   = entry_type'(rd_raw);
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign hit        = overlaps(rd_entry.low, rd_entry.high, s_ff, e_ff);
   assign last_entry = ({1'b0, chk_idx_ff} == CNT_W'(count_ff - 1'b1));
   assign table_full = (count_ff == CNT_W'(MAX_GROUPS));

   // read address: entry 0 at the transfer, then one ahead of the entry under test
   always_comb begin
      if (state_ff == ST_SCAN) begin
         rd_addr = chk_idx_ff + 1'b1;
      end else begin
         rd_addr = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      chk_idx_in   = chk_idx_ff;
      count_in     = count_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_entry     = '{low: s_ff, high: e_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_in = req_start_pos;
               e_in = req_end_pos;
               if (count_ff == '0) begin
                  // empty table: open block 0 straight away
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_entry     = '{low: req_start_pos, high: req_end_pos};
                  count_in     = CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_new_in   = 1'b1;
                  rsp_ovf_in   = 1'b0;
               end else begin
                  chk_idx_in = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // widen the block to the union and write it back
               wr_en         = 1'b1;
               wr_addr       = chk_idx_ff;
               wr_entry.low  = (s_ff < rd_entry.low)  ? s_ff : rd_entry.low;
               wr_entry.high = (e_ff > rd_entry.high) ? e_ff : rd_entry.high;
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = to_out_idx(chk_idx_ff);
               rsp_new_in    = 1'b0;
               rsp_ovf_in    = 1'b0;
               state_in      = ST_IDLE;
            end else if (last_entry) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (table_full) begin
                  rsp_idx_in = '0;
                  rsp_new_in = 1'b0;
                  rsp_ovf_in = 1'b1;
               end else begin
                  // append a new block at the end of the table
                  wr_en      = 1'b1;
                  wr_addr    = count_ff[IDX_W-1:0];
                  count_in   = count_ff + 1'b1;
                  rsp_idx_in = to_out_idx(count_ff[IDX_W-1:0]);
                  rsp_new_in = 1'b1;
                  rsp_ovf_in = 1'b0;
               end
            end else begin
               chk_idx_in = chk_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_idx_ff   <= chk_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s_ff       <= s_in;
      e_ff       <= e_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_new_ff <= rsp_new_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group_index = rsp_idx_ff;
   assign rsp_opened_new  = rsp_new_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   // a result never both opens a block and overflows
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_opened_new && rsp_overflow))
      else $error("result opened a block and overflowed");

   // block count stays within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_GROUPS))
      else $error("block count beyond table size");

   // scan never tests an entry past the stored blocks
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, chk_idx_ff} < count_ff))
      else $error("scan index past stored blocks");

   // overflow only with a full table, and the count is then unchanged
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> table_full && $stable(count_ff))
      else $error("overflow without a full table");

   // a new block raises the count by one
   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opened_new |-> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("new block without count increment");

   // a transfer either starts a scan or answers in the next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid)
      else $error("transfer neither scanned nor answered");
`endif

endmodule
